/* hw/rtl/gas_pkg.sv */
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, constants and helpers for the grid A* next-step block.
// ----------------------------------------------------------------------------
package gas_pkg;

   localparam int GRID_W_MAX = 64;
   localparam int GRID_H_MAX = 64;
   localparam int CELL_COUNT = GRID_W_MAX * GRID_H_MAX;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int COORD_W    = 6;
   localparam int DIM_W      = 7;
   localparam int LIMIT_W    = 16;
   localparam int CST_W      = 13;
   localparam int F_W        = 14;
   localparam int NB_W       = 4;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [1:0] CSR_IDX_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IDX_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_IDX_LIMIT  = 2'd2;

   localparam logic [DIM_W-1:0]   WIDTH_RST  = 7'd64;
   localparam logic [DIM_W-1:0]   HEIGHT_RST = 7'd64;
   localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd4000;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_SAME   = 2'd1,
      ST_NOPATH = 2'd2
   } status_type;

   typedef struct packed {
      logic cost_known;
      logic parent_known;
      logic open;
   } flag_type;

   typedef struct packed {
      logic [IDX_W-1:0] addr;
      logic             we_walk;
      logic             we_block;
      logic             we_flag;
      logic             we_cost;
      logic             we_parent;
      logic             walk;
      logic             block;
      flag_type         flag;
      logic [CST_W-1:0] cost;
      logic [IDX_W-1:0] parent;
   } mem_req_type;

   typedef struct packed {
      logic             walk;
      logic             block;
      flag_type         flag;
      logic [CST_W-1:0] cost;
      logic [IDX_W-1:0] parent;
   } mem_rsp_type;

   typedef struct packed {
      logic [1:0] dx;
      logic [1:0] dy;
   } nb_off_type;

   function automatic logic [IDX_W-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
      logic [IDX_W-1:0] r;
      r = IDX_W'(y) * IDX_W'(GRID_W_MAX) + IDX_W'(x);
      return r;
   endfunction

   // offset codes: 0 is minus one, 1 is zero, 2 is plus one
   function automatic nb_off_type nb_off(input logic [NB_W-1:0] nb);
      nb_off_type r;
      unique case (nb)
         4'd0:    r = '{dx: 2'd0, dy: 2'd0};
         4'd1:    r = '{dx: 2'd1, dy: 2'd0};
         4'd2:    r = '{dx: 2'd2, dy: 2'd0};
         4'd3:    r = '{dx: 2'd0, dy: 2'd1};
         4'd4:    r = '{dx: 2'd1, dy: 2'd1};
         4'd5:    r = '{dx: 2'd2, dy: 2'd1};
         4'd6:    r = '{dx: 2'd0, dy: 2'd2};
         4'd7:    r = '{dx: 2'd1, dy: 2'd2};
         4'd8:    r = '{dx: 2'd2, dy: 2'd2};
         default: r = '{dx: 2'd1, dy: 2'd1};
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/grid_astar_next_step_top.sv */
// ----------------------------------------------------------------------------
// grid_astar_next_step_top
// A* next-step finder on an 8-connected grid with a register port.
//
//   channel   ports                         transfer when
//   request   start, busy, req_*            start high and busy low
//   response  rsp_strobe, rsp_*             rsp_strobe high (one cycle)
//   config    csr_psel .. csr_prdata        psel, penable, pwrite high
//
// Cell write: done in idle. Clear blocked bits: all cells, one cell a cycle.
// Query: a flag clearing pass over all cells and a seed of the start, then per
// expansion the check, one scan of width*height cells through the shared
// compare unit, the scan end, the pick and the neighbor update, then the trace, one
// step per parent hop. Start equal to goal or out of bounds: answered from idle.
// After reset a pass clears the map over all cells; busy is high meanwhile.
// The receiver cannot stall; a response is shown for one cycle only.
// ----------------------------------------------------------------------------
module grid_astar_next_step_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  logic [gas_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [gas_pkg::COORD_W-1:0]  req_pos_y,
   input  logic                         req_walkable_bit,
   input  logic                         req_blocked_bit,
   input  logic [gas_pkg::COORD_W-1:0]  req_goal_x,
   input  logic [gas_pkg::COORD_W-1:0]  req_goal_y,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [gas_pkg::COORD_W-1:0]  rsp_step_x,
   output logic [gas_pkg::COORD_W-1:0]  rsp_step_y,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gas_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [gas_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [gas_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import gas_pkg::*;

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   mem_req_type        mem_req;
   mem_rsp_type        mem_rsp;
   status_type         res_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      limit_in  = limit_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            CSR_IDX_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            CSR_IDX_LIMIT:  limit_in  = csr_pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         CSR_IDX_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         CSR_IDX_LIMIT:  csr_prdata = CSR_DW'(limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         limit_ff  <= LIMIT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         limit_ff  <= limit_in;
      end
   end

   gas_cell_mem u_mem (
      .clock (clock),
      .req   (mem_req),
      .rsp   (mem_rsp)
   );

   gas_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .cmd             (cmd_type'(req_cmd)),
      .pos_x           (req_pos_x),
      .pos_y           (req_pos_y),
      .walkable_bit    (req_walkable_bit),
      .blocked_bit     (req_blocked_bit),
      .goal_x          (req_goal_x),
      .goal_y          (req_goal_y),
      .grid_width      (width_ff),
      .grid_height     (height_ff),
      .expansion_limit (limit_ff),
      .busy            (busy),
      .mem_req         (mem_req),
      .mem_rsp         (mem_rsp),
      .res_strobe      (rsp_strobe),
      .res_status      (res_status),
      .res_x           (rsp_step_x),
      .res_y           (rsp_step_y)
   );

   assign rsp_status = res_status;

   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_FOUND) |-> (rsp_step_x == '0) && (rsp_step_y == '0))
      else $error("step coordinates not zero on a no-step response");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_CLEAR) |=> busy)
      else $error("clear command did not start a sweep");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_FOUND) || (rsp_status == ST_SAME) ||
                     (rsp_status == ST_NOPATH))
      else $error("response status code out of range");

endmodule

/* hw/rtl/gas_cell_mem.sv */
// ----------------------------------------------------------------------------
// gas_cell_mem
// Per-cell storage: map bits, search flags, cost and parent; registered read.
// ----------------------------------------------------------------------------
module gas_cell_mem (
   input  logic                 clock,
   input  gas_pkg::mem_req_type req,
   output gas_pkg::mem_rsp_type rsp
);
   import gas_pkg::*;

   logic             walk_mem   [CELL_COUNT];
   logic             block_mem  [CELL_COUNT];
   flag_type         flag_mem   [CELL_COUNT];
   logic [CST_W-1:0] cost_mem   [CELL_COUNT];
   logic [IDX_W-1:0] parent_mem [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (req.we_walk) begin
         walk_mem[req.addr] <= req.walk;
      end
      if (req.we_block) begin
         block_mem[req.addr] <= req.block;
      end
      if (req.we_flag) begin
         flag_mem[req.addr] <= req.flag;
      end
      if (req.we_cost) begin
         cost_mem[req.addr] <= req.cost;
      end
      if (req.we_parent) begin
         parent_mem[req.addr] <= req.parent;
      end
      rsp.walk   <= walk_mem[req.addr];
      rsp.block  <= block_mem[req.addr];
      rsp.flag   <= flag_mem[req.addr];
      rsp.cost   <= cost_mem[req.addr];
      rsp.parent <= parent_mem[req.addr];
   end

endmodule

/* hw/rtl/gas_engine.sv */
// ----------------------------------------------------------------------------
// gas_engine
// Command sequencer: map writes, clearing sweeps, A* scan/expand and trace.
// ----------------------------------------------------------------------------
module gas_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  gas_pkg::cmd_type              cmd,
   input  logic [gas_pkg::COORD_W-1:0]   pos_x,
   input  logic [gas_pkg::COORD_W-1:0]   pos_y,
   input  logic                          walkable_bit,
   input  logic                          blocked_bit,
   input  logic [gas_pkg::COORD_W-1:0]   goal_x,
   input  logic [gas_pkg::COORD_W-1:0]   goal_y,
   input  logic [gas_pkg::DIM_W-1:0]     grid_width,
   input  logic [gas_pkg::DIM_W-1:0]     grid_height,
   input  logic [gas_pkg::LIMIT_W-1:0]   expansion_limit,
   output logic                          busy,
   output gas_pkg::mem_req_type          mem_req,
   input  gas_pkg::mem_rsp_type          mem_rsp,
   output logic                          res_strobe,
   output gas_pkg::status_type           res_status,
   output logic [gas_pkg::COORD_W-1:0]   res_x,
   output logic [gas_pkg::COORD_W-1:0]   res_y
);
   import gas_pkg::*;

   typedef enum logic [12:0] {
      S_INIT     = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_CLRB     = 13'b0000000000100,
      S_QCLR     = 13'b0000000001000,
      S_QSTART   = 13'b0000000010000,
      S_CHECK    = 13'b0000000100000,
      S_SCAN     = 13'b0000001000000,
      S_SCAN_END = 13'b0000010000000,
      S_PICK     = 13'b0000100000000,
      S_NB_ISSUE = 13'b0001000000000,
      S_NB_DEC   = 13'b0010000000000,
      S_TR0      = 13'b0100000000000,
      S_TR_CHK   = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic [COORD_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [LIMIT_W-1:0]  count_ff, count_in;
   logic [COORD_W-1:0]  scan_x_ff, scan_x_in, scan_y_ff, scan_y_in;
   logic                pv_ff, pv_in;
   logic [COORD_W-1:0]  pdx_ff, pdx_in, pdy_ff, pdy_in;
   logic                found_ff, found_in;
   logic [F_W-1:0]      bestf_ff, bestf_in;
   logic [COORD_W-1:0]  bx_ff, bx_in, by_ff, by_in;
   logic [CST_W-1:0]    bcost_ff, bcost_in;
   logic                bpk_ff, bpk_in;
   logic [NB_W-1:0]     nb_ff, nb_in;
   logic [CST_W-1:0]    g_ff, g_in;
   logic [COORD_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W:0]      trn_ff, trn_in;
   logic                strobe_ff, strobe_in;
   status_type          status_ff, status_in;
   logic [COORD_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;

   logic [DIM_W-1:0]    ew, eh;
   logic                sweep_last;
   logic [COORD_W-1:0]  hdx, hdy, hh;
   logic [F_W-1:0]      fval;
   nb_off_type          off;
   logic [7:0]          nx8, ny8;
   logic                nb_oob, nb_goal, nb_pass, nb_last;

   assign ew = (grid_width < DIM_W'(GRID_W_MAX)) ? grid_width : DIM_W'(GRID_W_MAX);
   assign eh = (grid_height < DIM_W'(GRID_H_MAX)) ? grid_height : DIM_W'(GRID_H_MAX);
   assign sweep_last = (sweep_ff == IDX_W'(CELL_COUNT - 1));

   assign hdx  = (gx_ff > pdx_ff) ? gx_ff - pdx_ff : pdx_ff - gx_ff;
   assign hdy  = (gy_ff > pdy_ff) ? gy_ff - pdy_ff : pdy_ff - gy_ff;
   assign hh   = (hdx > hdy) ? hdx : hdy;
   assign fval = {1'b0, mem_rsp.cost} + F_W'(hh);

   assign off    = nb_off(nb_ff);
   assign nx8    = {2'b00, bx_ff} + 8'(off.dx) - 8'd1;
   assign ny8    = {2'b00, by_ff} + 8'(off.dy) - 8'd1;
   assign nb_oob = (nx8 >= {1'b0, ew}) || (ny8 >= {1'b0, eh}) || (nb_ff == NB_W'(4));
   assign nb_last = (nb_ff == NB_W'(8));
   assign nb_goal = (nx_ff == gx_ff) && (ny_ff == gy_ff);
   assign nb_pass = nb_goal || (mem_rsp.walk && !mem_rsp.block);

   assign busy       = (state_ff != S_IDLE);
   assign res_strobe = strobe_ff;
   assign res_status = status_ff;
   assign res_x      = rx_ff;
   assign res_y      = ry_ff;

   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      count_in  = count_ff;
      scan_x_in = scan_x_ff;
      scan_y_in = scan_y_ff;
      pv_in     = 1'b0;
      pdx_in    = pdx_ff;
      pdy_in    = pdy_ff;
      found_in  = found_ff;
      bestf_in  = bestf_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      bcost_in  = bcost_ff;
      bpk_in    = bpk_ff;
      nb_in     = nb_ff;
      g_in      = g_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      cur_in    = cur_ff;
      trn_in    = trn_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      mem_req   = '0;

      // fold one scanned cell into the running minimum
      if (pv_ff && mem_rsp.flag.open && (!found_ff || fval < bestf_ff)) begin
         found_in = 1'b1;
         bestf_in = fval;
         bx_in    = pdx_ff;
         by_in    = pdy_ff;
         bcost_in = mem_rsp.cost;
         bpk_in   = mem_rsp.flag.parent_known;
      end

      unique case (state_ff)
         S_INIT: begin
            mem_req.addr     = sweep_ff;
            mem_req.we_walk  = 1'b1;
            mem_req.we_block = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_WRITE: begin
                     if (({1'b0, pos_x} < DIM_W'(GRID_W_MAX)) &&
                         ({1'b0, pos_y} < DIM_W'(GRID_H_MAX))) begin
                        mem_req.addr     = cell_idx(pos_x, pos_y);
                        mem_req.we_walk  = 1'b1;
                        mem_req.we_block = 1'b1;
                        mem_req.walk     = walkable_bit;
                        mem_req.block    = blocked_bit;
                     end
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_CLRB;
                  end
                  CMD_QUERY: begin
                     sx_in = pos_x;
                     sy_in = pos_y;
                     gx_in = goal_x;
                     gy_in = goal_y;
                     if ((pos_x == goal_x) && (pos_y == goal_y)) begin
                        strobe_in = 1'b1;
                        status_in = ST_SAME;
                        rx_in     = '0;
                        ry_in     = '0;
                     end else if (({1'b0, pos_x} >= ew) || ({1'b0, pos_y} >= eh)) begin
                        strobe_in = 1'b1;
                        status_in = ST_NOPATH;
                        rx_in     = '0;
                        ry_in     = '0;
                     end else begin
                        sweep_in = '0;
                        state_in = S_QCLR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLRB: begin
            mem_req.addr     = sweep_ff;
            mem_req.we_block = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_QCLR: begin
            mem_req.addr    = sweep_ff;
            mem_req.we_flag = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_QSTART;
            end
         end
         S_QSTART: begin
            mem_req.addr    = cell_idx(sx_ff, sy_ff);
            mem_req.we_flag = 1'b1;
            mem_req.we_cost = 1'b1;
            mem_req.flag    = '{cost_known: 1'b1, parent_known: 1'b0, open: 1'b1};
            mem_req.cost    = '0;
            count_in = '0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (count_ff < expansion_limit) begin
               found_in  = 1'b0;
               scan_x_in = '0;
               scan_y_in = '0;
               state_in  = S_SCAN;
            end else begin
               state_in = S_TR0;
            end
         end
         S_SCAN: begin
            mem_req.addr = cell_idx(scan_x_ff, scan_y_ff);
            pv_in  = 1'b1;
            pdx_in = scan_x_ff;
            pdy_in = scan_y_ff;
            if ({1'b0, scan_x_ff} == ew - 1'b1) begin
               scan_x_in = '0;
               if ({1'b0, scan_y_ff} == eh - 1'b1) begin
                  state_in = S_SCAN_END;
               end else begin
                  scan_y_in = scan_y_ff + 1'b1;
               end
            end else begin
               scan_x_in = scan_x_ff + 1'b1;
            end
         end
         S_SCAN_END: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (!found_ff) begin
               state_in = S_TR0;
            end else begin
               count_in        = count_ff + 1'b1;
               mem_req.addr    = cell_idx(bx_ff, by_ff);
               mem_req.we_flag = 1'b1;
               mem_req.flag    = '{cost_known: 1'b1, parent_known: bpk_ff, open: 1'b0};
               if ((bx_ff == gx_ff) && (by_ff == gy_ff)) begin
                  state_in = S_TR0;
               end else begin
                  g_in     = bcost_ff + 1'b1;
                  nb_in    = '0;
                  state_in = S_NB_ISSUE;
               end
            end
         end
         S_NB_ISSUE: begin
            if (nb_oob) begin
               if (nb_last) begin
                  state_in = S_CHECK;
               end else begin
                  nb_in = nb_ff + 1'b1;
               end
            end else begin
               nx_in        = nx8[COORD_W-1:0];
               ny_in        = ny8[COORD_W-1:0];
               mem_req.addr = cell_idx(nx8[COORD_W-1:0], ny8[COORD_W-1:0]);
               state_in     = S_NB_DEC;
            end
         end
         S_NB_DEC: begin
            if (nb_pass && (!mem_rsp.flag.cost_known || g_ff < mem_rsp.cost)) begin
               mem_req.addr      = cell_idx(nx_ff, ny_ff);
               mem_req.we_flag   = 1'b1;
               mem_req.we_cost   = 1'b1;
               mem_req.we_parent = 1'b1;
               mem_req.flag      = '{cost_known: 1'b1, parent_known: 1'b1, open: 1'b1};
               mem_req.cost      = g_ff;
               mem_req.parent    = cell_idx(bx_ff, by_ff);
            end
            if (nb_last) begin
               state_in = S_CHECK;
            end else begin
               nb_in    = nb_ff + 1'b1;
               state_in = S_NB_ISSUE;
            end
         end
         S_TR0: begin
            if (({1'b0, gx_ff} >= ew) || ({1'b0, gy_ff} >= eh)) begin
               strobe_in = 1'b1;
               status_in = ST_NOPATH;
               rx_in     = '0;
               ry_in     = '0;
               state_in  = S_IDLE;
            end else begin
               mem_req.addr = cell_idx(gx_ff, gy_ff);
               cur_in       = cell_idx(gx_ff, gy_ff);
               trn_in       = '0;
               state_in     = S_TR_CHK;
            end
         end
         S_TR_CHK: begin
            if (!mem_rsp.flag.parent_known || (trn_ff == (IDX_W + 1)'(CELL_COUNT))) begin
               strobe_in = 1'b1;
               status_in = ST_NOPATH;
               rx_in     = '0;
               ry_in     = '0;
               state_in  = S_IDLE;
            end else if (mem_rsp.parent == cell_idx(sx_ff, sy_ff)) begin
               strobe_in = 1'b1;
               status_in = ST_FOUND;
               rx_in     = COORD_W'(cur_ff % IDX_W'(GRID_W_MAX));
               ry_in     = COORD_W'(cur_ff / IDX_W'(GRID_W_MAX));
               state_in  = S_IDLE;
            end else begin
               trn_in       = trn_ff + 1'b1;
               mem_req.addr = mem_rsp.parent;
               cur_in       = mem_rsp.parent;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         sweep_ff  <= '0;
         pv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         pv_ff     <= pv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      count_ff  <= count_in;
      scan_x_ff <= scan_x_in;
      scan_y_ff <= scan_y_in;
      pdx_ff    <= pdx_in;
      pdy_ff    <= pdy_in;
      found_ff  <= found_in;
      bestf_ff  <= bestf_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      bcost_ff  <= bcost_in;
      bpk_ff    <= bpk_in;
      nb_ff     <= nb_in;
      g_ff      <= g_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      cur_ff    <= cur_in;
      trn_ff    <= trn_in;
      status_ff <= status_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
   end

endmodule
